### hdl/lsrc_pkg.sv
package lsrc_pkg;

  localparam int COORD_W    = 32;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int QUO_W      = DIFF_W;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int OFF_W      = QUO_W + 1;
  // magnitude stage + product stage + one stage per quotient bit + sign stage
  localparam int INTERP_LAT = QUO_W + 3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [OFF_W-1:0]   off_t;

  typedef struct packed {
    coord_t rect_x1;
    coord_t rect_y1;
    coord_t rect_x2;
    coord_t rect_y2;
    coord_t seg_start_x;
    coord_t seg_start_y;
    coord_t seg_end_x;
    coord_t seg_end_y;
  } in_item_t;

  typedef struct packed {
    logic   visible;
    coord_t clip_start_x;
    coord_t clip_start_y;
    coord_t clip_end_x;
    coord_t clip_end_y;
  } out_item_t;

  // classified item: trivial reject plus normalized rectangle and segment endpoints
  typedef struct packed {
    logic   reject;
    coord_t xmin;
    coord_t xmax;
    coord_t ymin;
    coord_t ymax;
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
  } rect_seg_t;

  function automatic diff_t sdiff(coord_t a, coord_t b);
    return diff_t'(a) - diff_t'(b);
  endfunction

  function automatic coord_t add_off(coord_t p, off_t o);
    off_t s;
    s = off_t'(p) + o;
    return s[COORD_W-1:0];
  endfunction

endpackage

### hdl/line_segment_rect_clip.sv
// channel   direction  handshake            payload
// item      in         push / full          in_item_t  (rectangle corners, segment)
// result    out        pop / empty          out_item_t (visible, clipped endpoints)
//
// One item per cycle sustained while the result queue keeps draining; items pass through
// the two 33-stage restoring divider pipelines in series.
// Reset (rst, synchronous) empties both queues and clears pipeline valids.
// A stalled result queue freezes the back pipeline; the input queue then fills and raises full.
module line_segment_rect_clip import lsrc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  item,
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  localparam int RS_W  = $bits(rect_seg_t);
  localparam int RES_W = $bits(out_item_t);

  rect_seg_t        rs_in;
  logic [RS_W-1:0]  q_rdata;
  logic             q_empty;
  logic             head_pop;
  out_item_t        res;
  logic             res_valid;
  logic             o_full;
  logic [RES_W-1:0] o_rdata;

  lsrc_front u_front (.item(item), .rs(rs_in));

  lsrc_fifo #(.WIDTH(RS_W), .DEPTH(2)) u_cls_q (
    .clk(clk), .rst(rst),
    .push(push), .wdata(rs_in), .full(full),
    .pop(head_pop), .rdata(q_rdata), .empty(q_empty)
  );

  lsrc_back u_back (
    .clk(clk), .rst(rst),
    .head(rect_seg_t'(q_rdata)), .head_valid(!q_empty), .head_pop(head_pop),
    .res(res), .res_valid(res_valid), .res_ready(!o_full)
  );

  lsrc_fifo #(.WIDTH(RES_W), .DEPTH(2)) u_res_q (
    .clk(clk), .rst(rst),
    .push(res_valid), .wdata(res), .full(o_full),
    .pop(pop), .rdata(o_rdata), .empty(empty)
  );

  assign result = out_item_t'(o_rdata);

endmodule

### hdl/lsrc_fifo.sv
module lsrc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

### hdl/lsrc_front.sv
module lsrc_front import lsrc_pkg::*; (
  input  in_item_t  item,
  output rect_seg_t rs
);

  coord_t xmin, xmax, ymin, ymax;
  coord_t ax, ay, bx, by;

  assign ax   = item.seg_start_x;
  assign ay   = item.seg_start_y;
  assign bx   = item.seg_end_x;
  assign by   = item.seg_end_y;
  assign xmin = (item.rect_x1 < item.rect_x2) ? item.rect_x1 : item.rect_x2;
  assign xmax = (item.rect_x1 < item.rect_x2) ? item.rect_x2 : item.rect_x1;
  assign ymin = (item.rect_y1 < item.rect_y2) ? item.rect_y1 : item.rect_y2;
  assign ymax = (item.rect_y1 < item.rect_y2) ? item.rect_y2 : item.rect_y1;

  always_comb begin
    rs.reject = (ax < xmin && bx < xmin) || (ax > xmax && bx > xmax) ||
                (ay < ymin && by < ymin) || (ay > ymax && by > ymax);
    rs.xmin = xmin;
    rs.xmax = xmax;
    rs.ymin = ymin;
    rs.ymax = ymax;
    rs.ax   = ax;
    rs.ay   = ay;
    rs.bx   = bx;
    rs.by   = by;
  end

endmodule

### hdl/lsrc_interp.sv
// off = trunc(dp * num / den), pipelined restoring divide, one quotient bit per stage.
// Quotient magnitude is bounded by |dp| since |num| <= |den| where it is used.
module lsrc_interp import lsrc_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  diff_t dp,
  input  diff_t num,
  input  diff_t den,
  output off_t  off
);

  logic [DIFF_W-1:0] m_dp, m_num, m_den;
  logic              m_neg;
  logic [PROD_W-1:0] prod;

  logic [DIFF_W-1:0] r   [0:QUO_W];
  logic [QUO_W-1:0]  lo  [0:QUO_W];
  logic [QUO_W-1:0]  q   [0:QUO_W];
  logic [DIFF_W-1:0] d   [0:QUO_W];
  logic              neg [0:QUO_W];

  logic [DIFF_W:0]   t   [0:QUO_W-1];
  logic [DIFF_W:0]   td  [0:QUO_W-1];
  logic              ge  [0:QUO_W-1];

  function automatic logic [DIFF_W-1:0] mag(diff_t a);
    return a[DIFF_W-1] ? DIFF_W'(-a) : DIFF_W'(a);
  endfunction

  assign prod = m_dp * m_num;

  always_comb begin
    for (int k = 0; k < QUO_W; k++) begin
      t[k]  = {r[k], lo[k][QUO_W-1-k]};
      td[k] = t[k] - {1'b0, d[k]};
      ge[k] = (t[k] >= {1'b0, d[k]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_dp   <= mag(dp);
      m_num  <= mag(num);
      m_den  <= mag(den);
      m_neg  <= dp[DIFF_W-1] ^ num[DIFF_W-1] ^ den[DIFF_W-1];

      r[0]   <= prod[PROD_W-1:QUO_W];
      lo[0]  <= prod[QUO_W-1:0];
      q[0]   <= '0;
      d[0]   <= m_den;
      neg[0] <= m_neg;

      for (int k = 0; k < QUO_W; k++) begin
        r[k+1]   <= ge[k] ? td[k][DIFF_W-1:0] : t[k][DIFF_W-1:0];
        q[k+1]   <= {q[k][QUO_W-2:0], ge[k]};
        lo[k+1]  <= lo[k];
        d[k+1]   <= d[k];
        neg[k+1] <= neg[k];
      end

      off <= neg[QUO_W] ? -off_t'({1'b0, q[QUO_W]}) : off_t'({1'b0, q[QUO_W]});
    end
  end

endmodule

### hdl/lsrc_back.sv
// Interpolation runs in an x-edge phase (find y), then in a y-edge phase (find x).
// Whole pipeline advances together; holds only when the result register is stuck.
module lsrc_back import lsrc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  rect_seg_t head,
  input  logic      head_valid,
  output logic      head_pop,
  output out_item_t res,
  output logic      res_valid,
  input  logic      res_ready
);

  localparam int L = INTERP_LAT;

  typedef struct packed {
    rect_seg_t rs;
    coord_t    sx;
    coord_t    sy;
    coord_t    ex;
    coord_t    ey;
    logic      s_mv;
    logic      e_mv;
    logic      vert;
    logic      horiz;
  } ctx_t;

  logic en;

  ctx_t  ctx_a [0:L];
  logic  vld_a [0:L];
  ctx_t  ctx_b [0:L];
  logic  vld_b [0:L];

  ctx_t  a_next, b_next, a, b;
  diff_t opa_dp, opa_den, opa_s, opa_e;
  diff_t opb_dp, opb_den, opb_s, opb_e;
  diff_t na_dp, na_den, na_s, na_e;
  diff_t nb_dp, nb_den, nb_s, nb_e;
  off_t  offa_s, offa_e, offb_s, offb_e;
  out_item_t res_next;

  assign en       = !res_valid || res_ready;
  assign head_pop = en && head_valid;

  // x phase setup
  always_comb begin
    logic s_xl, s_xr, e_xl, e_xr;
    s_xl = head.ax < head.xmin;
    s_xr = head.ax > head.xmax;
    e_xl = head.bx < head.xmin;
    e_xr = head.bx > head.xmax;
    a_next.rs    = head;
    a_next.sx    = s_xl ? head.xmin : (s_xr ? head.xmax : head.ax);
    a_next.sy    = head.ay;
    a_next.ex    = e_xl ? head.xmin : (e_xr ? head.xmax : head.bx);
    a_next.ey    = head.by;
    a_next.s_mv  = s_xl || s_xr;
    a_next.e_mv  = e_xl || e_xr;
    a_next.vert  = (head.bx == head.ax);
    a_next.horiz = (head.by == head.ay);
    na_dp  = sdiff(head.by, head.ay);
    na_den = sdiff(head.bx, head.ax);
    na_s   = sdiff(a_next.sx, head.ax);
    na_e   = sdiff(a_next.ex, head.ax);
  end

  // x phase result, y phase setup
  always_comb begin
    coord_t s_py, e_py;
    logic   s_yt, s_yb, e_yt, e_yb;
    a    = ctx_a[L];
    s_py = (a.s_mv && !a.vert) ? add_off(a.rs.ay, offa_s) : a.sy;
    e_py = (a.e_mv && !a.vert) ? add_off(a.rs.ay, offa_e) : a.ey;
    s_yt = s_py > a.rs.ymax;
    s_yb = s_py < a.rs.ymin;
    e_yt = e_py > a.rs.ymax;
    e_yb = e_py < a.rs.ymin;
    b_next       = a;
    b_next.sy    = s_yt ? a.rs.ymax : (s_yb ? a.rs.ymin : s_py);
    b_next.ey    = e_yt ? a.rs.ymax : (e_yb ? a.rs.ymin : e_py);
    b_next.s_mv  = s_yt || s_yb;
    b_next.e_mv  = e_yt || e_yb;
    nb_dp  = sdiff(a.rs.bx, a.rs.ax);
    nb_den = sdiff(a.rs.by, a.rs.ay);
    nb_s   = sdiff(b_next.sy, a.rs.ay);
    nb_e   = sdiff(b_next.ey, a.rs.ay);
  end

  // y phase result and final point-collapse check
  always_comb begin
    coord_t s_px, e_px;
    logic   vis;
    b = ctx_b[L];
    if (!b.s_mv) begin
      s_px = b.sx;
    end else if (b.vert) begin
      s_px = b.rs.ax;
    end else if (b.horiz) begin
      s_px = b.sx;
    end else begin
      s_px = add_off(b.rs.ax, offb_s);
    end
    if (!b.e_mv) begin
      e_px = b.ex;
    end else if (b.vert) begin
      e_px = b.rs.ax;
    end else if (b.horiz) begin
      e_px = b.ex;
    end else begin
      e_px = add_off(b.rs.ax, offb_e);
    end
    vis = !b.rs.reject &&
          !(s_px == e_px && b.sy == b.ey && (s_px < b.rs.xmin || s_px > b.rs.xmax));
    res_next.visible      = vis;
    res_next.clip_start_x = vis ? s_px : '0;
    res_next.clip_start_y = vis ? b.sy : '0;
    res_next.clip_end_x   = vis ? e_px : '0;
    res_next.clip_end_y   = vis ? b.ey : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= L; k++) begin
        vld_a[k] <= 1'b0;
        vld_b[k] <= 1'b0;
      end
      res_valid <= 1'b0;
    end else if (en) begin
      vld_a[0] <= head_valid;
      vld_b[0] <= vld_a[L];
      for (int k = 0; k < L; k++) begin
        vld_a[k+1] <= vld_a[k];
        vld_b[k+1] <= vld_b[k];
      end
      res_valid <= vld_b[L];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_a[0] <= a_next;
      ctx_b[0] <= b_next;
      for (int k = 0; k < L; k++) begin
        ctx_a[k+1] <= ctx_a[k];
        ctx_b[k+1] <= ctx_b[k];
      end
      opa_dp  <= na_dp;
      opa_den <= na_den;
      opa_s   <= na_s;
      opa_e   <= na_e;
      opb_dp  <= nb_dp;
      opb_den <= nb_den;
      opb_s   <= nb_s;
      opb_e   <= nb_e;
      res     <= res_next;
    end
  end

  lsrc_interp u_ia_s (.clk(clk), .en(en), .dp(opa_dp), .num(opa_s), .den(opa_den), .off(offa_s));
  lsrc_interp u_ia_e (.clk(clk), .en(en), .dp(opa_dp), .num(opa_e), .den(opa_den), .off(offa_e));
  lsrc_interp u_ib_s (.clk(clk), .en(en), .dp(opb_dp), .num(opb_s), .den(opb_den), .off(offb_s));
  lsrc_interp u_ib_e (.clk(clk), .en(en), .dp(opb_dp), .num(opb_e), .den(opb_den), .off(offb_e));

endmodule

### tb/sv/line_segment_rect_clip_tb.sv
`timescale 1ns / 1ps

module line_segment_rect_clip_tb;
  import lsrc_pkg::*;

  logic      clk;
  logic      rst;
  logic      push;
  logic      full;
  in_item_t  item;
  logic      empty;
  logic      pop;
  out_item_t result;

  out_item_t pending_clips[$];
  int        error_count;
  bit        steady;        // no idling on either side while set
  int        rx_hold;       // cycles the receiver still holds off
  int        results_seen;

  line_segment_rect_clip u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------- predictor ----------------
  function automatic logic [63:0] mag64(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // p0 + trunc(dp * num / den), product kept exact
  function automatic longint interp_on_line(longint p0, longint dp, longint num,
                                            longint den);
    logic          neg;
    logic [127:0]  prod;
    logic [127:0]  quo;
    logic [63:0]   q;
    neg  = ((dp < 0) != (num < 0)) != (den < 0);
    prod = 128'(mag64(dp)) * 128'(mag64(num));
    quo  = prod / 128'(mag64(den));
    q    = quo[63:0];
    if (q > (64'd1 << 62)) q = 64'd1 << 62;
    return neg ? p0 - longint'(q) : p0 + longint'(q);
  endfunction

  function automatic void snap_to_rect(inout longint px, inout longint py,
                                       input longint xmin, xmax, ymin, ymax,
                                       input longint ax, ay, bx, by);
    if (px < xmin) begin
      px = xmin;
      if (bx != ax) py = interp_on_line(ay, by - ay, px - ax, bx - ax);
    end
    if (px > xmax) begin
      px = xmax;
      if (bx != ax) py = interp_on_line(ay, by - ay, px - ax, bx - ax);
    end
    if (py > ymax) begin
      py = ymax;
      if (bx == ax) px = ax;
      else if (by != ay) px = interp_on_line(ax, bx - ax, py - ay, by - ay);
    end
    if (py < ymin) begin
      py = ymin;
      if (bx == ax) px = ax;
      else if (by != ay) px = interp_on_line(ax, bx - ax, py - ay, by - ay);
    end
  endfunction

  function automatic out_item_t clip_segment(in_item_t it);
    out_item_t r;
    longint x1, y1, x2, y2, ax, ay, bx, by;
    longint xmin, xmax, ymin, ymax, sx, sy, ex, ey;
    x1 = it.rect_x1;     y1 = it.rect_y1;
    x2 = it.rect_x2;     y2 = it.rect_y2;
    ax = it.seg_start_x; ay = it.seg_start_y;
    bx = it.seg_end_x;   by = it.seg_end_y;
    xmin = (x1 < x2) ? x1 : x2;  xmax = (x1 < x2) ? x2 : x1;
    ymin = (y1 < y2) ? y1 : y2;  ymax = (y1 < y2) ? y2 : y1;
    r = '0;
    if ((ax < xmin && bx < xmin) || (ax > xmax && bx > xmax) ||
        (ay < ymin && by < ymin) || (ay > ymax && by > ymax))
      return r;
    sx = ax; sy = ay; ex = bx; ey = by;
    snap_to_rect(sx, sy, xmin, xmax, ymin, ymax, ax, ay, bx, by);
    snap_to_rect(ex, ey, xmin, xmax, ymin, ymax, ax, ay, bx, by);
    // collapsed to one point off the x range
    if (sx == ex && sy == ey && (sx < xmin || sx > xmax))
      return r;
    r.visible      = 1'b1;
    r.clip_start_x = sx[COORD_W-1:0];
    r.clip_start_y = sy[COORD_W-1:0];
    r.clip_end_x   = ex[COORD_W-1:0];
    r.clip_end_y   = ey[COORD_W-1:0];
    return r;
  endfunction

  // ---------------- sender ----------------
  task automatic send_item(in_item_t it);
    while (!steady && $urandom_range(0, 99) < 26) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    pending_clips.push_back(clip_segment(it));
  endtask

  task automatic go_quiet();
    push <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_clips.size() != 0) @(posedge clk);
  endtask

  // ---------------- receiver and checker ----------------
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      pop <= 1'b0;
    end else begin
      pop <= steady || ($urandom_range(0, 99) >= 26);
    end
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    error_count++;
    $display("mismatch %s: got %h want %h (result %0d)", what, got, want, results_seen);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && pop && !empty) begin
      if (pending_clips.size() == 0) begin
        report_mismatch("unexpected item", 32'(result.visible), '0);
      end else begin
        want = pending_clips.pop_front();
        if (result.visible !== want.visible)
          report_mismatch("visible", 32'(result.visible), 32'(want.visible));
        if (result.clip_start_x !== want.clip_start_x)
          report_mismatch("clip_start_x", result.clip_start_x, want.clip_start_x);
        if (result.clip_start_y !== want.clip_start_y)
          report_mismatch("clip_start_y", result.clip_start_y, want.clip_start_y);
        if (result.clip_end_x !== want.clip_end_x)
          report_mismatch("clip_end_x", result.clip_end_x, want.clip_end_x);
        if (result.clip_end_y !== want.clip_end_y)
          report_mismatch("clip_end_y", result.clip_end_y, want.clip_end_y);
      end
      results_seen++;
    end
  end

  // ---------------- stimulus ----------------
  function automatic in_item_t make_item(int r1x, r1y, r2x, r2y, ax, ay, bx, by);
    in_item_t it;
    it.rect_x1 = r1x; it.rect_y1 = r1y; it.rect_x2 = r2x; it.rect_y2 = r2y;
    it.seg_start_x = ax; it.seg_start_y = ay; it.seg_end_x = bx; it.seg_end_y = by;
    return it;
  endfunction

  function automatic in_item_t random_segment();
    in_item_t it;
    int       span;
    it = in_item_t'({$urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom});
    case ($urandom_range(0, 5))
      0: ;  // full-range noise
      1, 2, 3: begin
        // segment around a modest rectangle, often crossing it
        span = 1 << $urandom_range(4, 24);
        it.rect_x1     = $signed($urandom_range(0, span)) - span / 2;
        it.rect_y1     = $signed($urandom_range(0, span)) - span / 2;
        it.rect_x2     = $signed($urandom_range(0, span)) - span / 2;
        it.rect_y2     = $signed($urandom_range(0, span)) - span / 2;
        it.seg_start_x = $signed($urandom_range(0, 2 * span)) - span;
        it.seg_start_y = $signed($urandom_range(0, 2 * span)) - span;
        it.seg_end_x   = $signed($urandom_range(0, 2 * span)) - span;
        it.seg_end_y   = $signed($urandom_range(0, 2 * span)) - span;
        if ($urandom_range(0, 7) == 0) it.seg_end_x = it.seg_start_x;
        if ($urandom_range(0, 7) == 0) it.seg_end_y = it.seg_start_y;
      end
      default: begin
        // huge segment through a random rectangle
        if ($urandom_range(0, 1)) it.seg_start_x = 32'h8000_0000;
        if ($urandom_range(0, 1)) it.seg_end_x   = 32'h7fff_ffff;
        if ($urandom_range(0, 1)) it.seg_start_y = 32'h7fff_ffff;
        if ($urandom_range(0, 1)) it.seg_end_y   = 32'h8000_0000;
      end
    endcase
    return it;
  endfunction

  task automatic test_directed();
    int mn, mx;
    mn = 32'h8000_0000; mx = 32'h7fff_ffff;
    send_item(make_item(0, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(mx, mx, mx, mx, mx, mx, mx, mx));
    send_item(make_item(mn, mn, mn, mn, mn, mn, mn, mn));
    send_item(make_item(mn, mn, mx, mx, mn, mn, mx, mx));
    send_item(make_item(mx, mx, mn, mn, mx, mn, mn, mx));
    send_item(make_item(-100, -100, 100, 100, mn, mx, mx, mn));
    // reject beyond each side
    send_item(make_item(-10, -10, 10, 10, -30, -5, -20, 5));
    send_item(make_item(-10, -10, 10, 10, 30, -5, 20, 5));
    send_item(make_item(-10, -10, 10, 10, -5, 30, 5, 20));
    send_item(make_item(-10, -10, 10, 10, -5, -30, 5, -20));
    // vertical, horizontal, single point
    send_item(make_item(10, 10, -10, -10, 3, -50, 3, 50));
    send_item(make_item(10, 10, -10, -10, -50, 4, 50, 4));
    send_item(make_item(-10, -10, 10, 10, 2, 2, 2, 2));
    send_item(make_item(-10, -10, 10, 10, 20, 20, 20, 20));
    // segments near corners: two misses, one crossing
    send_item(make_item(0, 0, 10, 10, -5, 8, 8, 20));
    send_item(make_item(0, 0, 10, 10, -20, 5, 5, -20));
    send_item(make_item(0, 0, 10, 10, 12, -3, -1, 13));
    // degenerate rectangles, then two ordinary ones
    send_item(make_item(5, 0, 5, 10, 0, 0, 10, 10));
    send_item(make_item(0, 5, 10, 5, 0, 0, 10, 10));
    send_item(make_item(5, 5, 5, 5, 0, 0, 10, 10));
    send_item(make_item(0, 0, 7, 7, 0, 0, 7, 7));
    send_item(make_item(-65536, -65536, 65536, 65536, mn, 1, mx, -1));
    go_quiet();
  endtask

  task automatic test_random(int n, bit no_idle);
    steady = no_idle;
    repeat (n) send_item(random_segment());
    steady = 1'b0;
    go_quiet();
  endtask

  // receiver stalls long enough that the input side must push back
  task automatic test_backpressure();
    rx_hold = 400;
    repeat (200) send_item(random_segment());
    go_quiet();
  endtask

  task automatic test_drain_then_send();
    wait_drained();
    repeat (50) @(posedge clk);
    repeat (20) send_item(random_segment());
    go_quiet();
  endtask

  initial begin
    rst = 1'b1;
    push = 1'b0;
    item = '0;
    steady = 1'b0;
    rx_hold = 0;
    error_count = 0;
    results_seen = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(600, 1'b0);
    test_random(300, 1'b1);
    test_backpressure();
    test_drain_then_send();
    test_random(600, 1'b0);
    wait_drained();
    repeat (150) @(posedge clk);
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
